>>> hw/rtl/rwsu_pkg.sv
// ----------------------------------------------------------------------------
// Readout word stream unpacker package
// Shared types, result codes, register indexes and small decode functions.
// ----------------------------------------------------------------------------
package rwsu_pkg;

    localparam int SAMPLE_W  = 9;
    localparam int MAX_BURST = 7;
    localparam int TIME_W    = 45;
    localparam int EPOCH_W   = 30;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [LEN_W-1:0] EPOCH_LEN_RESET = 16'd20480;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_AVG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_LEN    = 2'd1;

    typedef enum logic [1:0] {
        KIND_HIT   = 2'd0,
        KIND_EPOCH = 2'd1,
        KIND_INFO  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    localparam logic [2:0] ERR_STRAY   = 3'd0;
    localparam logic [2:0] ERR_MISSING = 3'd1;
    localparam logic [2:0] ERR_NULL    = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN = 3'd3;

    localparam logic [2:0] INFO_BOM = 3'd0;
    localparam logic [2:0] INFO_MSB = 3'd1;
    localparam logic [2:0] INFO_BUF = 3'd2;
    localparam logic [2:0] INFO_UNU = 3'd3;
    localparam logic [2:0] INFO_MIS = 3'd4;

    localparam logic [2:0] EPOCH_STEP = 3'd0;
    localparam logic [2:0] EPOCH_JUMP = 3'd1;

    localparam logic [2:0] HIT_CODE = 3'd0;

    typedef struct packed {
        logic             avg_mode;
        logic [LEN_W-1:0] epoch_len;
    } t_cfg;

    // all results of one word: a shared header and up to seven samples
    typedef struct packed {
        t_kind                                kind;
        logic [5:0]                           elink;
        logic [3:0]                           channel;
        logic [15:0]                          link;
        logic [1:0]                           hit_kind;
        logic                                 multi;
        logic [5:0]                           total;
        logic [TIME_W-1:0]                    full_time;
        logic [2:0]                           code;
        logic [4:0]                           first_idx;
        logic [2:0]                           count;
        logic [MAX_BURST-1:0][SAMPLE_W-1:0]   samples;
    } t_bundle;

    function automatic logic [2:0] words_needed(input logic [5:0] total);
        logic [2:0] res;
        if (total < 6'd4)       res = 3'd0;
        else if (total < 6'd11) res = 3'd1;
        else if (total < 6'd18) res = 3'd2;
        else if (total < 6'd25) res = 3'd3;
        else if (total < 6'd32) res = 3'd4;
        else                    res = 3'd5;
        return res;
    endfunction

    function automatic logic [2:0] info_code(input logic [2:0] info_type);
        logic [2:0] res;
        case (info_type)
            3'd6, 3'd7: res = INFO_BOM;
            3'd3:       res = INFO_BUF;
            3'd4:       res = INFO_UNU;
            3'd5:       res = INFO_MIS;
            default:    res = INFO_MSB;
        endcase
        return res;
    endfunction

endpackage

>>> hw/rtl/rwsu_if.sv
// ----------------------------------------------------------------------------
// Readout word stream unpacker channels
// Valid/ready channels for readout words, results and register writes.
// ----------------------------------------------------------------------------
interface rwsu_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic        slice_end;
    logic [15:0] link_id;

    modport source (output valid, data_word, slice_end, link_id, input ready);
    modport sink   (input valid, data_word, slice_end, link_id, output ready);
endinterface

interface rwsu_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [5:0]         elink;
    logic [3:0]         channel;
    logic [15:0]        link;
    logic [1:0]         hit_kind;
    logic               multi_hit;
    logic [5:0]         sample_total;
    logic [44:0]        full_time;
    logic [4:0]         sample_index;
    logic signed [8:0]  sample_value;
    logic [2:0]         code;
    logic               last_of_item;

    modport source (output valid, event_kind, elink, channel, link, hit_kind, multi_hit,
                    sample_total, full_time, sample_index, sample_value, code,
                    last_of_item, input ready);
    modport sink   (input valid, event_kind, elink, channel, link, hit_kind, multi_hit,
                    sample_total, full_time, sample_index, sample_value, code,
                    last_of_item, output ready);
endinterface

interface rwsu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/rwsu_decode.sv
// ----------------------------------------------------------------------------
// Readout word decoder
// Registers one readout word, classifies it against the slice state and
// hands all of its results to the serialiser as one bundle.
// ----------------------------------------------------------------------------
module rwsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rwsu_in_if.sink          i_in,
    input  rwsu_pkg::t_cfg   i_cfg,
    output rwsu_pkg::t_bundle o_bundle,
    output logic             o_bundle_valid,
    input  logic             i_bundle_ready
);

    // input register
    logic        r_in_valid;
    logic [63:0] r_word;
    logic        r_end;
    logic [15:0] r_link;

    // slice state
    logic [rwsu_pkg::EPOCH_W-1:0] r_epoch, n_epoch;
    logic [2:0]                   r_cont_left, n_cont_left;
    logic [5:0]                   r_next_sample, n_next_sample;
    logic                         r_skip, n_skip;

    // hit header, written at hit start before any read
    logic [5:0]                  r_held_elink, n_held_elink;
    logic [3:0]                  r_held_channel, n_held_channel;
    logic [15:0]                 r_held_link, n_held_link;
    logic [1:0]                  r_held_hit_kind, n_held_hit_kind;
    logic                        r_held_multi, n_held_multi;
    logic [5:0]                  r_held_total, n_held_total;
    logic [rwsu_pkg::TIME_W-1:0] r_held_time, n_held_time;

    logic        w_commit;
    logic [45:0] w_product;
    logic [rwsu_pkg::TIME_W-1:0] w_hit_time;
    logic [5:0]  w_hit_total;
    logic [5:0]  w_rem;
    logic [2:0]  w_cont_cnt;
    logic [29:0] w_epoch_val;
    logic        w_epoch_jump;
    rwsu_pkg::t_bundle w_bundle;

    assign w_product   = r_epoch * i_cfg.epoch_len;
    assign w_hit_time  = w_product[44:0] + {34'd0, r_word[45:35]};
    assign w_hit_total = {1'b0, r_word[31:27]} + 6'd1;
    assign w_rem       = r_held_total - r_next_sample;
    assign w_cont_cnt  = (w_rem > 6'd7) ? 3'd7 : w_rem[2:0];
    assign w_epoch_val = r_word[61:32];
    assign w_epoch_jump = ({1'b0, w_epoch_val} != ({1'b0, r_epoch} + 31'd1));

    always_comb begin
        w_bundle        = '0;
        n_epoch         = r_epoch;
        n_cont_left     = r_cont_left;
        n_next_sample   = r_next_sample;
        n_skip          = r_skip;
        n_held_elink    = r_held_elink;
        n_held_channel  = r_held_channel;
        n_held_link     = r_held_link;
        n_held_hit_kind = r_held_hit_kind;
        n_held_multi    = r_held_multi;
        n_held_total    = r_held_total;
        n_held_time     = r_held_time;

        if (r_skip) begin
            // rest of the slice dropped
        end else if (r_cont_left != 3'd0) begin
            if (r_word[63]) begin
                w_bundle.kind      = rwsu_pkg::KIND_HIT;
                w_bundle.elink     = r_held_elink;
                w_bundle.channel   = r_held_channel;
                w_bundle.link      = r_held_link;
                w_bundle.hit_kind  = r_held_hit_kind;
                w_bundle.multi     = r_held_multi;
                w_bundle.total     = r_held_total;
                w_bundle.full_time = r_held_time;
                w_bundle.code      = rwsu_pkg::HIT_CODE;
                w_bundle.first_idx = r_next_sample[4:0];
                w_bundle.count     = w_cont_cnt;
                for (int j = 0; j < rwsu_pkg::MAX_BURST; j++) begin
                    w_bundle.samples[j] = r_word[62-9*j -: 9];
                end
                n_cont_left   = r_cont_left - 3'd1;
                n_next_sample = r_next_sample + {3'd0, w_cont_cnt};
            end else begin
                w_bundle.kind  = rwsu_pkg::KIND_ERROR;
                w_bundle.code  = rwsu_pkg::ERR_MISSING;
                w_bundle.count = 3'd1;
                n_cont_left    = 3'd0;
                n_skip         = 1'b1;
            end
        end else if (r_word[63:61] == 3'b001) begin
            n_held_elink    = r_word[60:55];
            n_held_channel  = r_word[54:51];
            n_held_hit_kind = r_word[34:33];
            n_held_multi    = r_word[32];
            n_held_total    = w_hit_total;
            n_held_link     = r_link;
            n_held_time     = w_hit_time;
            w_bundle.kind      = rwsu_pkg::KIND_HIT;
            w_bundle.elink     = n_held_elink;
            w_bundle.channel   = n_held_channel;
            w_bundle.link      = n_held_link;
            w_bundle.hit_kind  = n_held_hit_kind;
            w_bundle.multi     = n_held_multi;
            w_bundle.total     = n_held_total;
            w_bundle.full_time = n_held_time;
            w_bundle.code      = rwsu_pkg::HIT_CODE;
            w_bundle.first_idx = 5'd0;
            w_bundle.count     = (w_hit_total < 6'd3) ? w_hit_total[2:0] : 3'd3;
            // baseline averaging keeps extra precision in sample zero
            if (i_cfg.avg_mode && !r_word[32]) begin
                w_bundle.samples[0] = {2'b10, r_word[26:20]};
            end else begin
                w_bundle.samples[0] = r_word[26:18];
            end
            w_bundle.samples[1] = r_word[17:9];
            w_bundle.samples[2] = r_word[8:0];
            n_cont_left   = rwsu_pkg::words_needed(w_hit_total);
            n_next_sample = 6'd3;
        end else if (r_word[63]) begin
            w_bundle.kind  = rwsu_pkg::KIND_ERROR;
            w_bundle.code  = rwsu_pkg::ERR_STRAY;
            w_bundle.count = 3'd1;
            n_skip         = 1'b1;
        end else if (r_word[62]) begin
            w_bundle.kind      = rwsu_pkg::KIND_EPOCH;
            w_bundle.full_time = {15'd0, w_epoch_val};
            w_bundle.code      = w_epoch_jump ? rwsu_pkg::EPOCH_JUMP : rwsu_pkg::EPOCH_STEP;
            w_bundle.count     = 3'd1;
            n_epoch            = w_epoch_val;
        end else if (r_word[60]) begin
            w_bundle.kind  = rwsu_pkg::KIND_INFO;
            w_bundle.code  = rwsu_pkg::info_code(r_word[19:17]);
            w_bundle.count = 3'd1;
        end else if (r_word == 64'd0) begin
            if (!r_end) begin
                w_bundle.kind  = rwsu_pkg::KIND_ERROR;
                w_bundle.code  = rwsu_pkg::ERR_NULL;
                w_bundle.count = 3'd1;
            end
        end else begin
            w_bundle.kind  = rwsu_pkg::KIND_ERROR;
            w_bundle.code  = rwsu_pkg::ERR_UNKNOWN;
            w_bundle.count = 3'd1;
        end

        // slice end abandons any open hit
        if (r_end) begin
            n_skip      = 1'b0;
            n_cont_left = 3'd0;
        end
    end

    assign o_bundle       = w_bundle;
    assign o_bundle_valid = r_in_valid && (w_bundle.count != 3'd0);
    // words with no result retire without waiting on the serialiser
    assign w_commit       = r_in_valid && (!o_bundle_valid || i_bundle_ready);
    assign i_in.ready     = !r_in_valid || w_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_epoch       <= '0;
            r_cont_left   <= '0;
            r_next_sample <= '0;
            r_skip        <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_commit) begin
                r_in_valid <= 1'b0;
            end
            if (w_commit) begin
                r_epoch       <= n_epoch;
                r_cont_left   <= n_cont_left;
                r_next_sample <= n_next_sample;
                r_skip        <= n_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word <= i_in.data_word;
            r_end  <= i_in.slice_end;
            r_link <= i_in.link_id;
        end
        if (w_commit) begin
            r_held_elink    <= n_held_elink;
            r_held_channel  <= n_held_channel;
            r_held_link     <= n_held_link;
            r_held_hit_kind <= n_held_hit_kind;
            r_held_multi    <= n_held_multi;
            r_held_total    <= n_held_total;
            r_held_time     <= n_held_time;
        end
    end

endmodule

>>> hw/rtl/rwsu_serial.sv
// ----------------------------------------------------------------------------
// Result serialiser
// Holds one bundle and moves its results into the output register, one per
// cycle unless o_out stalls; takes the next bundle as the last result leaves.
// ----------------------------------------------------------------------------
module rwsu_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwsu_pkg::t_bundle i_bundle,
    input  logic              i_bundle_valid,
    output logic              o_bundle_ready,
    rwsu_out_if.source        o_out
);

    rwsu_pkg::t_bundle r_bundle;
    logic [2:0]        r_left;
    logic [2:0]        r_pos;

    logic                 r_out_valid;
    rwsu_pkg::t_kind      r_out_kind;
    logic [5:0]           r_out_elink;
    logic [3:0]           r_out_channel;
    logic [15:0]          r_out_link;
    logic [1:0]           r_out_hit_kind;
    logic                 r_out_multi;
    logic [5:0]           r_out_total;
    logic [44:0]          r_out_time;
    logic [4:0]           r_out_idx;
    logic [8:0]           r_out_sample;
    logic [2:0]           r_out_code;
    logic                 r_out_last;

    logic w_advance;
    logic w_load;

    assign w_advance      = (r_left != 3'd0) && (!r_out_valid || o_out.ready);
    assign o_bundle_ready = (r_left == 3'd0) || ((r_left == 3'd1) && w_advance);
    assign w_load         = i_bundle_valid && o_bundle_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_left <= i_bundle.count;
                r_pos  <= 3'd0;
            end else if (w_advance) begin
                r_left <= r_left - 3'd1;
                r_pos  <= r_pos + 3'd1;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bundle <= i_bundle;
        end
        if (w_advance) begin
            r_out_kind     <= r_bundle.kind;
            r_out_elink    <= r_bundle.elink;
            r_out_channel  <= r_bundle.channel;
            r_out_link     <= r_bundle.link;
            r_out_hit_kind <= r_bundle.hit_kind;
            r_out_multi    <= r_bundle.multi;
            r_out_total    <= r_bundle.total;
            r_out_time     <= r_bundle.full_time;
            r_out_idx      <= r_bundle.first_idx + {2'd0, r_pos};
            r_out_sample   <= r_bundle.samples[r_pos];
            r_out_code     <= r_bundle.code;
            r_out_last     <= (r_left == 3'd1);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_out_kind;
    assign o_out.elink        = r_out_elink;
    assign o_out.channel      = r_out_channel;
    assign o_out.link         = r_out_link;
    assign o_out.hit_kind     = r_out_hit_kind;
    assign o_out.multi_hit    = r_out_multi;
    assign o_out.sample_total = r_out_total;
    assign o_out.full_time    = r_out_time;
    assign o_out.sample_index = r_out_idx;
    assign o_out.sample_value = $signed(r_out_sample);
    assign o_out.code         = r_out_code;
    assign o_out.last_of_item = r_out_last;

endmodule

>>> hw/rtl/readout_word_stream_unpacker.sv
// ----------------------------------------------------------------------------
// Readout word stream unpacker
// Decodes microslice readout words into hit samples, epoch, info and error
// results, with two run-time registers.
// ----------------------------------------------------------------------------
// path: a taken word goes through the input, bundle and output registers
// throughput: one word per cycle while o_out accepts and each gives at most
//   one result; up to 7 results hold the serialiser, leaving one per cycle
// reset: synchronous active low; clears slice state, epoch count, valid flags
//   and registers (epoch length back to 20480), with no clearing pass
module readout_word_stream_unpacker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rwsu_in_if.sink     i_in,
    rwsu_out_if.source  o_out,
    rwsu_cfg_if.sink    i_cfg
);

    logic                          r_avg_mode;
    logic [rwsu_pkg::LEN_W-1:0]    r_epoch_len;
    rwsu_pkg::t_cfg                w_cfg;
    rwsu_pkg::t_bundle             w_bundle;
    logic                          w_bundle_valid;
    logic                          w_bundle_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_mode  <= 1'b0;
            r_epoch_len <= rwsu_pkg::EPOCH_LEN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rwsu_pkg::REG_BASELINE_AVG: r_avg_mode  <= i_cfg.data[0];
                rwsu_pkg::REG_EPOCH_LEN:    r_epoch_len <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_cfg.avg_mode  = r_avg_mode;
    assign w_cfg.epoch_len = r_epoch_len;

    rwsu_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_cfg          (w_cfg),
        .o_bundle       (w_bundle),
        .o_bundle_valid (w_bundle_valid),
        .i_bundle_ready (w_bundle_ready)
    );

    rwsu_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bundle       (w_bundle),
        .i_bundle_valid (w_bundle_valid),
        .o_bundle_ready (w_bundle_ready),
        .o_out          (o_out)
    );

    // epoch, info and error requests are single results
    a_single_non_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.event_kind != rwsu_pkg::KIND_HIT) |-> o_out.last_of_item)
        else $error("non-hit result not marked last");

    a_non_hit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.event_kind != rwsu_pkg::KIND_HIT)
        |-> (o_out.sample_index == 5'd0) && (o_out.sample_value == 9'sd0)
            && (o_out.sample_total == 6'd0))
        else $error("non-hit result carries sample fields");

    a_index_in_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.event_kind == rwsu_pkg::KIND_HIT)
        |-> ({1'b0, o_out.sample_index} < o_out.sample_total))
        else $error("sample index beyond hit sample count");

endmodule
